>>> rtl/csr_spmv_pkg.sv
package csr_spmv_pkg;

    localparam int VEC_DEPTH   = 4096;
    localparam int VEC_ADDR_W  = $clog2(VEC_DEPTH);
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 64;
    localparam int ROW_W       = 16;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = OUT_PTR_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NONZERO = 2'd1,
        OP_CLOSE   = 2'd2
    } op_t;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [VEC_ADDR_W-1:0] addr;
    } vec_req_t;

    typedef struct packed {
        logic                    saturated;
        logic [ROW_W-1:0]        row_number;
        logic signed [SUM_W-1:0] row_sum;
    } result_t;

endpackage

>>> rtl/csr_spmv_core_top.sv
// CSR sparse matrix times dense vector.
// Input channel s_*: one beat per stream item. s_tuser carries the operation
// (load vector entry, matrix nonzero, close empty row), s_tlast marks the last
// nonzero of a row, s_tdata carries column and Q16.16 value.
// Output channel m_*: one beat per finished row with the saturated Q32.32 sum,
// the row number and a flag that is set when the row's accumulation clipped.
// Throughput: one item per cycle in steady state while s_tready is high, also
// while rows finish back to back. The single-port-write, registered-read
// vector store, the product register and the accumulator make a three-stage
// path: a row result goes through the gather and product registers and is
// written by the accumulator stage into the result queue that drives m_tvalid.
// A four-entry result queue sits at the output; s_tready counts the results
// still in the pipeline against free queue slots, so a stalled receiver
// stops intake only when the queue would otherwise overflow.
// Reset (aresetn low, synchronous) clears the accumulator, row counter,
// clip flag, pipeline and queue. The vector store is not cleared: load every
// entry before a nonzero reads it.
module csr_sparse_matrix_vector_multiply_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // column[11:0], operand_value[43:12], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // row_sum[63:0], row_number[79:64]
    output logic        m_tuser    // saturated[0]
);
    import csr_spmv_pkg::*;

    logic                    s_fire;
    op_t                     s_op;
    logic [VEC_ADDR_W-1:0]   s_column;
    logic signed [VAL_W-1:0] s_value;
    logic                    s_add;
    logic                    s_fin;
    vec_req_t                vec_req;
    logic signed [VAL_W-1:0] vec_rd_data;

    logic                    p1_valid_reg;
    logic                    p1_add_reg;
    logic                    p1_fin_reg;
    logic signed [VAL_W-1:0] p1_val_reg;

    logic                    p2_valid_reg;
    logic                    p2_add_reg;
    logic                    p2_fin_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] prod_next;

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic                    clip_reg;
    logic                    clip_next;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;

    logic [SUM_W:0]          sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    sum_clip;

    result_t                 fifo_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]    wr_ptr_reg;
    logic [OUT_PTR_W-1:0]    rd_ptr_reg;
    logic [OUT_CNT_W-1:0]    cnt_reg;
    logic [OUT_CNT_W-1:0]    cnt_next;
    logic [OUT_CNT_W:0]      pending;
    logic                    fifo_push;
    logic                    fifo_pop;
    result_t                 push_data;
    result_t                 head;

    assign s_op     = op_t'(s_tuser);
    assign s_column = s_tdata[VEC_ADDR_W-1:0];
    assign s_value  = s_tdata[VEC_ADDR_W +: VAL_W];
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        s_add = 1'b0;
        s_fin = 1'b0;
        unique case (s_op)
            OP_LOAD:    s_add = 1'b0;
            OP_NONZERO: begin
                s_add = 1'b1;
                s_fin = s_tlast;
            end
            OP_CLOSE:   s_fin = 1'b1;
            default:    s_add = 1'b0;
        endcase
    end

    assign vec_req.wr_en = s_fire && (s_op == OP_LOAD);
    assign vec_req.rd_en = s_fire && (s_op == OP_NONZERO);
    assign vec_req.addr  = s_column;

    csr_spmv_vec_store u_vec_store (
        .aclk    (aclk),
        .req     (vec_req),
        .wr_data (s_value),
        .rd_data (vec_rd_data)
    );

    // stage 1: gather
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_add_reg   <= 1'b0;
            p1_fin_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= s_fire && (s_add || s_fin);
            p1_add_reg   <= s_fire && s_add;
            p1_fin_reg   <= s_fire && s_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_val_reg <= s_value;
        end
    end

    // stage 2: multiply
    assign prod_next = p1_val_reg * vec_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p2_add_reg   <= 1'b0;
            p2_fin_reg   <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
            p2_add_reg   <= p1_add_reg;
            p2_fin_reg   <= p1_fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_add_reg) begin
            prod_reg <= prod_next;
        end
    end

    // stage 3: saturating accumulate
    always_comb begin
        sum_wide = {acc_reg[SUM_W-1], acc_reg} + {prod_reg[SUM_W-1], prod_reg};
        sum_clip = 1'b0;
        sum_sat  = acc_reg;
        if (p2_add_reg) begin
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                sum_clip = 1'b1;
                sum_sat  = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_sat = sum_wide[SUM_W-1:0];
            end
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        row_next  = row_reg;
        if (p2_valid_reg) begin
            if (p2_fin_reg) begin
                acc_next  = '0;
                clip_next = 1'b0;
                row_next  = row_reg + 1'b1;
            end else begin
                acc_next  = sum_sat;
                clip_next = clip_reg | sum_clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            acc_reg  <= acc_next;
            clip_reg <= clip_next;
            row_reg  <= row_next;
        end
    end

    // result queue
    assign fifo_push            = p2_valid_reg && p2_fin_reg;
    assign push_data.row_sum    = sum_sat;
    assign push_data.row_number = row_reg;
    assign push_data.saturated  = clip_reg | sum_clip;
    assign fifo_pop             = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        priority if (fifo_push && !fifo_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (fifo_pop && !fifo_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (fifo_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (fifo_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // results in flight hold a queue slot each
    assign pending = {1'b0, cnt_reg}
                   + {{OUT_CNT_W{1'b0}}, (p1_valid_reg && p1_fin_reg)}
                   + {{OUT_CNT_W{1'b0}}, (p2_valid_reg && p2_fin_reg)};
    assign s_tready = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));

    assign head     = fifo_mem_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {head.row_number, head.row_sum};
    assign m_tuser  = head.saturated;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (cnt_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("row result pushed into a full queue");

    a_row_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |=> (acc_reg == '0) && !clip_reg && (row_reg == $past(row_reg) + 1'b1))
        else $error("accumulator not cleared after a row result");

    a_pipe_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_add_reg || p2_fin_reg) |-> p2_valid_reg)
        else $error("stage flags set without a valid item");
`endif

endmodule

>>> rtl/csr_spmv_vec_store.sv
module csr_spmv_vec_store (
    input  logic                               aclk,
    input  csr_spmv_pkg::vec_req_t             req,
    input  logic signed [csr_spmv_pkg::VAL_W-1:0] wr_data,
    output logic signed [csr_spmv_pkg::VAL_W-1:0] rd_data
);
    import csr_spmv_pkg::*;

    logic signed [VAL_W-1:0] mem [VEC_DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> dv/csr_spmv_checker.sv
`timescale 1ns / 1ps

module csr_spmv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // column[11:0], operand_value[43:12], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        s_tlast,   // row_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // row_sum[63:0], row_number[79:64]
    input  logic        m_tuser,   // saturated[0]
    output int          fail_count,
    output int          rows_pending,
    output int          rows_checked,
    output int          rows_clipped
);
    import csr_spmv_pkg::*;

    logic signed [VAL_W-1:0] vector_mirror [VEC_DEPTH];
    logic signed [SUM_W-1:0] row_acc;
    logic [ROW_W-1:0]        row_index;
    logic                    row_clipped;
    result_t                 row_sums_due [$];

    int mismatches   = 0;
    int due_count    = 0;
    int checked      = 0;
    int clipped_seen = 0;

    assign fail_count   = mismatches;
    assign rows_pending = due_count;
    assign rows_checked = checked;
    assign rows_clipped = clipped_seen;

    function automatic logic signed [SUM_W-1:0] clip_add(
        input  logic signed [SUM_W-1:0] a,
        input  logic signed [SUM_W-1:0] b,
        output logic                    clipped
    );
        logic signed [SUM_W:0] wide;
        wide    = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        clipped = wide[SUM_W] != wide[SUM_W-1];
        if (clipped) begin
            return {wide[SUM_W], {(SUM_W-1){~wide[SUM_W]}}};
        end
        return wide[SUM_W-1:0];
    endfunction

    function automatic void compare_field(
        input string            label,
        input logic [ROW_W-1:0] row,
        input logic [SUM_W-1:0] want,
        input logic [SUM_W-1:0] got
    );
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] row %0d %s: expected %h, got %h", $realtime, row, label,
                         want, got);
            end
        end
    endfunction

    function automatic void finish_row();
        result_t r;
        r.row_sum    = row_acc;
        r.row_number = row_index;
        r.saturated  = row_clipped;
        row_sums_due.push_back(r);
        row_acc     = '0;
        row_clipped = 1'b0;
        row_index   = row_index + 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        logic [VEC_ADDR_W-1:0]   col;
        logic signed [VAL_W-1:0] val;
        logic signed [SUM_W-1:0] lhs, rhs;
        logic                    clipped;
        result_t                 want;
        if (!aresetn) begin
            row_acc     = '0;
            row_index   = '0;
            row_clipped = 1'b0;
            row_sums_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (row_sums_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected row beat: sum %h row %0d flag %b",
                                 $realtime, m_tdata[63:0], m_tdata[79:64], m_tuser);
                    end
                end else begin
                    want = row_sums_due.pop_front();
                    checked++;
                    if (want.saturated) begin
                        clipped_seen++;
                    end
                    compare_field("row_sum", want.row_number, want.row_sum, m_tdata[63:0]);
                    compare_field("row_number", want.row_number, SUM_W'(want.row_number),
                                  SUM_W'(m_tdata[79:64]));
                    compare_field("saturated", want.row_number, SUM_W'(want.saturated),
                                  SUM_W'(m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                col = s_tdata[11:0];
                val = s_tdata[43:12];
                case (s_tuser)
                    OP_LOAD: begin
                        vector_mirror[col] = val;
                    end
                    OP_NONZERO: begin
                        lhs     = val;
                        rhs     = vector_mirror[col];
                        row_acc = clip_add(row_acc, lhs * rhs, clipped);
                        if (clipped) begin
                            row_clipped = 1'b1;
                        end
                        if (s_tlast) begin
                            finish_row();
                        end
                    end
                    OP_CLOSE: begin
                        finish_row();
                    end
                    default: begin
                    end
                endcase
            end
        end
        due_count = row_sums_due.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import csr_spmv_pkg::*;

    localparam logic [1:0] OP_NOOP      = 2'd3;
    localparam int         STREAM_ITEMS = 450;
    localparam int         DRAIN_CYCLES = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // column[11:0], operand_value[43:12], zero pad
    logic [1:0]  s_tuser;   // operation[1:0]
    logic        s_tlast;   // row_end
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // row_sum[63:0], row_number[79:64]
    logic        m_tuser;   // saturated[0]

    int fail_count;
    int rows_pending;
    int rows_checked;
    int rows_clipped;

    int beats_sent;
    int noise_sent;
    int burst_left;

    logic                  loaded [VEC_DEPTH];
    logic [VEC_ADDR_W-1:0] loaded_cols [$];

    csr_sparse_matrix_vector_multiply_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    csr_spmv_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked),
        .rows_clipped (rows_clipped)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400us;
        $display("FAIL");
        $finish;
    end

    // receiver backpressure in spans of varying density
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        logic [19:0] frac;
        frac = 20'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_0000;
                    default: return 32'h0001_0000;
                endcase
            end
            1:       return {{12{frac[19]}}, frac};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VEC_ADDR_W-1:0] pick_column();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    task automatic send_item(
        input logic [1:0]            op,
        input logic [VEC_ADDR_W-1:0] col,
        input logic [VAL_W-1:0]      val,
        input logic                  last
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tdata  <= {4'b0, val, col};
        s_tuser  <= op;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (op == OP_NOOP) begin
            noise_sent++;
        end else begin
            beats_sent++;
        end
        if (op == OP_LOAD && !loaded[col]) begin
            loaded[col] = 1'b1;
            loaded_cols.push_back(col);
        end
    endtask

    initial begin
        int kind;
        int n;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_LOAD;
        s_tlast    = 1'b0;
        beats_sent = 0;
        noise_sent = 0;
        burst_left = 0;
        foreach (loaded[i]) begin
            loaded[i] = 1'b0;
        end
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // vector extremes, row-end mark on a load is ignored
        send_item(OP_LOAD, 12'h000, 32'h7fff_ffff, 1'b0);
        send_item(OP_LOAD, 12'hfff, 32'h8000_0000, 1'b1);
        send_item(OP_LOAD, 12'haaa, 32'h0001_0000, 1'b0);
        send_item(OP_LOAD, 12'h555, 32'hffff_0000, 1'b0);
        // positive clip, then a later addition starts from the clipped value
        send_item(OP_NONZERO, 12'hfff, 32'h8000_0000, 1'b0);
        send_item(OP_NONZERO, 12'hfff, 32'h8000_0000, 1'b0);
        send_item(OP_NONZERO, 12'haaa, 32'hffff_0000, 1'b1);
        // empty row, mark ignored
        send_item(OP_CLOSE, 12'hfff, 32'hffff_ffff, 1'b1);
        // negative clip
        send_item(OP_NONZERO, 12'h000, 32'h8000_0000, 1'b0);
        send_item(OP_NONZERO, 12'h000, 32'h8000_0000, 1'b0);
        send_item(OP_NONZERO, 12'h000, 32'h8000_0000, 1'b1);
        // close with a sum still pending
        send_item(OP_NONZERO, 12'h555, 32'h7fff_ffff, 1'b0);
        send_item(OP_NONZERO, 12'haaa, 32'h0003_8000, 1'b0);
        send_item(OP_CLOSE, 12'h000, 32'h0000_0000, 1'b0);
        // reserved operation changes nothing
        send_item(OP_NOOP, 12'hfff, 32'hffff_ffff, 1'b1);
        send_item(OP_NONZERO, 12'haaa, 32'h0000_0000, 1'b1);
        send_item(OP_NONZERO, 12'h000, 32'h7fff_ffff, 1'b1);
        send_item(OP_NONZERO, 12'hfff, 32'h7fff_ffff, 1'b0);
        send_item(OP_NONZERO, 12'h555, 32'h0000_0001, 1'b1);
        send_item(OP_CLOSE, 12'h000, 32'h0000_0000, 1'b0);

        while (beats_sent < STREAM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(OP_LOAD, 12'($urandom), pick_value(),
                                     1'($urandom_range(0, 1)));
            end else if (kind < 18) begin
                send_item(OP_CLOSE, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else if (kind < 22) begin
                send_item(OP_NOOP, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else if (kind < 30) begin
                // row left open, then closed by the empty-row operation
                n = $urandom_range(1, 4);
                repeat (n) send_item(OP_NONZERO, pick_column(), pick_value(), 1'b0);
                send_item(OP_CLOSE, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    send_item(OP_NONZERO, pick_column(), pick_value(), k == n - 1);
                end
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait (rows_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d stream beats plus %0d reserved-op beats, %0d vector entries loaded",
                 beats_sent, noise_sent, loaded_cols.size());
        $display("%0d row sums checked, %0d of them saturated", rows_checked, rows_clipped);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/csr_spmv_pkg.sv
rtl/csr_spmv_vec_store.sv
rtl/csr_spmv_core_top.sv
dv/csr_spmv_checker.sv
dv/tb_top.sv
